// ----- rtl/core/ghpm_pkg.sv -----
// ----------------------------------------------------------------------------
// ghpm_pkg
// Shared types, codes and default sizes of the grid hash point merge core.
// ----------------------------------------------------------------------------
package ghpm_pkg;

    // default sizes (bucket count must be a power of two)
    localparam int CAPACITY_DEF    = 8192;
    localparam int BUCKETS_DEF     = 1024;
    localparam int MAX_MATCHES_DEF = 63;

    // cell divider: dividend covers a probe offset from the box corner,
    // divisor covers 2r
    localparam int DIV_NUM_W  = 32;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STEP_W = 6;

    // request types
    localparam logic [1:0] REQ_INSERT        = 2'd0;
    localparam logic [1:0] REQ_INSERT_UNIQUE = 2'd1;
    localparam logic [1:0] REQ_FIND_FIRST    = 2'd2;
    localparam logic [1:0] REQ_FIND_ALL      = 2'd3;

    // result status
    localparam logic [2:0] ST_MATCHED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_NONE     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_OUTSIDE  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_BOX_MIN_X    = 3'd0;
    localparam logic [2:0] CFG_BOX_MIN_Y    = 3'd1;
    localparam logic [2:0] CFG_BOX_MAX_X    = 3'd2;
    localparam logic [2:0] CFG_BOX_MAX_Y    = 3'd3;
    localparam logic [2:0] CFG_MATCH_RADIUS = 3'd4;
    localparam logic [2:0] CFG_ROW_STRIDE   = 3'd5;

    // configuration reset values
    localparam logic [31:0] BOX_MAX_RST  = 32'd65536;
    localparam logic [29:0] RADIUS_RST   = 30'd1;
    localparam logic [15:0] STRIDE_RST   = 16'd90;

    typedef struct packed {
        logic [31:0] box_min_x;
        logic [31:0] box_min_y;
        logic [31:0] box_max_x;
        logic [31:0] box_max_y;
        logic [29:0] match_radius;
        logic [15:0] row_stride;
    } cfg_t;

endpackage

// ----- rtl/core/ghpm_div.sv -----
// ----------------------------------------------------------------------------
// ghpm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghpm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ghpm_pkg::DIV_NUM_W-1:0]  num,
    input  logic [ghpm_pkg::DIV_DEN_W-1:0]  den,
    output logic                            done,
    output logic [ghpm_pkg::DIV_NUM_W-1:0]  quo
);

    localparam int NW = ghpm_pkg::DIV_NUM_W;
    localparam int DW = ghpm_pkg::DIV_DEN_W;
    localparam int SW = ghpm_pkg::DIV_STEP_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;

    // one restoring step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        trial     = shifted - {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (run_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SW'(NW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/core/ghpm_seq.sv -----
// ----------------------------------------------------------------------------
// ghpm_seq
// Request sequencer: cell numbers, bucket list, chain walk, inserts, results.
// Holds the bucket head memory and the point memory.
// ----------------------------------------------------------------------------
module ghpm_seq #(
    parameter int CAPACITY    = ghpm_pkg::CAPACITY_DEF,
    parameter int BUCKETS     = ghpm_pkg::BUCKETS_DEF,
    parameter int MAX_MATCHES = ghpm_pkg::MAX_MATCHES_DEF,
    localparam int IDX_W      = $clog2(CAPACITY)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ghpm_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [31:0]        coord_x,
    input  logic [31:0]        coord_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   point_index,
    output logic [2:0]         status,
    output logic               last_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int NF_W  = $clog2(MAX_MATCHES + 1);
    localparam int PT_W  = 65 + IDX_W;
    localparam int NW    = ghpm_pkg::DIV_NUM_W;
    localparam int DW    = ghpm_pkg::DIV_DEN_W;

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_CLEAR    = 17'b00000000000000010,
        S_DIVSTART = 17'b00000000000000100,
        S_DIVWAIT  = 17'b00000000000001000,
        S_MUL      = 17'b00000000000010000,
        S_BKT      = 17'b00000000000100000,
        S_HEAD     = 17'b00000000001000000,
        S_HEADWAIT = 17'b00000000010000000,
        S_PTWAIT   = 17'b00000000100000000,
        S_SQX      = 17'b00000001000000000,
        S_SQY      = 17'b00000010000000000,
        S_CMP      = 17'b00000100000000000,
        S_NEXT     = 17'b00001000000000000,
        S_INS      = 17'b00010000000000000,
        S_INSW     = 17'b00100000000000000,
        S_OUT      = 17'b01000000000000000,
        S_OVF      = 17'b10000000000000000
    } state_t;

    // memories
    logic [IDX_W:0]   head_mem [BUCKETS];
    logic [PT_W-1:0]  pt_mem   [CAPACITY];
    logic [IDX_W:0]   head_rdata_reg;
    logic [PT_W-1:0]  pt_rdata_reg;
    logic             head_we, head_re, pt_we, pt_re;
    logic [BKT_W-1:0] head_waddr, head_raddr;
    logic [IDX_W:0]   head_wdata;
    logic [IDX_W-1:0] pt_waddr, pt_raddr;
    logic [PT_W-1:0]  pt_wdata;

    // control registers
    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [BKT_W-1:0] clr_reg, clr_next;
    logic             axy_reg, axy_next;
    logic [1:0]       axi_reg, axi_next;
    logic [1:0]       pi_reg, pi_next;
    logic [1:0]       pj_reg, pj_next;
    logic [2:0]       nb_reg, nb_next;
    logic [2:0]       k_reg, k_next;
    logic [NF_W-1:0]  nf_reg, nf_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [1:0]       req_reg, req_next;
    logic [31:0]      x_reg, x_next;
    logic [31:0]      y_reg, y_next;
    logic [59:0]      rr_reg, rr_next;
    logic [31:0]      cqx_reg [3];
    logic [31:0]      cqx_next [3];
    logic [31:0]      cqy_reg [3];
    logic [31:0]      cqy_next [3];
    logic [47:0]      prod_reg, prod_next;
    logic [BKT_W-1:0] list_reg [4];
    logic [BKT_W-1:0] list_next [4];
    logic [BKT_W-1:0] cbkt_reg, cbkt_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] link_reg, link_next;
    logic             linkv_reg, linkv_next;
    logic             near_reg, near_next;
    logic [29:0]      ax_reg, ax_next;
    logic [29:0]      ay_reg, ay_next;
    logic [59:0]      sqx_reg, sqx_next;
    logic [59:0]      sqy_reg, sqy_next;
    logic [IDX_W-1:0] pend_reg, pend_next;
    logic [IDX_W-1:0] o_idx_reg, o_idx_next;
    logic [2:0]       o_st_reg, o_st_next;
    logic             o_last_reg, o_last_next;
    logic [IDX_W-1:0] oidx_reg, oidx_next;
    logic [2:0]       ost_reg, ost_next;
    logic             olast_reg, olast_next;

    // datapath
    logic [29:0]        r_val;
    logic [28:0]        h_val;
    logic signed [33:0] x34, y34, h34, minx34, miny34, maxx34, maxy34;
    logic signed [33:0] offx [3];
    logic signed [33:0] offy [3];
    logic [31:0]        difx [3];
    logic [31:0]        dify [3];
    logic [2:0]         inx, iny;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic               div_start, div_done;
    logic [NW-1:0]      div_num, div_quo;
    logic [DW-1:0]      div_den;
    logic [BKT_W-1:0]   bkt;
    logic               dup;
    logic               probe_in, probe_last;
    logic signed [32:0] ddx, ddy;
    logic [32:0]        adx, ady;
    logic [60:0]        dist_sum;
    logic               close;
    logic               accept;
    state_t             after_probe;

    ghpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // radius, half step and probe coordinates
    always_comb
    begin
        r_val  = (cfg.match_radius == '0) ? 30'd1 : cfg.match_radius;
        h_val  = r_val[29:1];
        x34    = {{2{x_reg[31]}}, x_reg};
        y34    = {{2{y_reg[31]}}, y_reg};
        h34    = {5'b0, h_val};
        minx34 = {{2{cfg.box_min_x[31]}}, cfg.box_min_x};
        miny34 = {{2{cfg.box_min_y[31]}}, cfg.box_min_y};
        maxx34 = {{2{cfg.box_max_x[31]}}, cfg.box_max_x};
        maxy34 = {{2{cfg.box_max_y[31]}}, cfg.box_max_y};
        offx[0] = x34 - h34;
        offx[1] = x34;
        offx[2] = x34 + h34;
        offy[0] = y34 - h34;
        offy[1] = y34;
        offy[2] = y34 + h34;
        for (int n = 0; n < 3; n++)
        begin
            inx[n]  = (offx[n] >= minx34) && (offx[n] < maxx34);
            iny[n]  = (offy[n] >= miny34) && (offy[n] < maxy34);
            difx[n] = 32'(offx[n] - minx34);
            dify[n] = 32'(offy[n] - miny34);
        end
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MUL:
            begin
                mul_a = cqy_reg[pj_reg];
                mul_b = {16'b0, cfg.row_stride};
            end
            S_SQX:
            begin
                mul_a = {2'b0, ax_reg};
                mul_b = {2'b0, ax_reg};
            end
            S_SQY:
            begin
                mul_a = {2'b0, ay_reg};
                mul_b = {2'b0, ay_reg};
            end
            default:
            begin
                mul_a = {2'b0, r_val};
                mul_b = {2'b0, r_val};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // divider operands: probe offset over cell width
    always_comb
    begin
        div_num = axy_reg ? NW'(dify[axi_reg]) : NW'(difx[axi_reg]);
        div_den = DW'({r_val, 1'b0});
    end

    // bucket fold (power-of-two bucket count), dedup and distance test
    always_comb
    begin
        bkt = BKT_W'(cqx_reg[pi_reg]) + BKT_W'(prod_reg);
        dup = 1'b0;
        for (int n = 0; n < 4; n++)
        begin
            if ((3'(n) < nb_reg) && (list_reg[n] == bkt))
                dup = 1'b1;
        end
        probe_in   = inx[pi_reg] && iny[pj_reg];
        probe_last = (pi_reg == 2'd2) && (pj_reg == 2'd2);
        after_probe = (req_reg == ghpm_pkg::REQ_INSERT) ? S_INS : S_HEAD;
        ddx = $signed({x_reg[31], x_reg}) - $signed({pt_rdata_reg[PT_W-1], pt_rdata_reg[PT_W-1 -: 32]});
        ddy = $signed({y_reg[31], y_reg}) - $signed({pt_rdata_reg[PT_W-33], pt_rdata_reg[PT_W-33 -: 32]});
        adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
        ady = ddy[32] ? 33'(-ddy) : 33'(ddy);
        dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        close    = near_reg && (dist_sum < {1'b0, rr_reg});
    end

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_next       = clr_reg;
        axy_next       = axy_reg;
        axi_next       = axi_reg;
        pi_next        = pi_reg;
        pj_next        = pj_reg;
        nb_next        = nb_reg;
        k_next         = k_reg;
        nf_next        = nf_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        req_next       = req_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rr_next        = rr_reg;
        cqx_next       = cqx_reg;
        cqy_next       = cqy_reg;
        prod_next      = prod_reg;
        list_next      = list_reg;
        cbkt_next      = cbkt_reg;
        p_next         = p_reg;
        link_next      = link_reg;
        linkv_next     = linkv_reg;
        near_next      = near_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        pend_next      = pend_reg;
        o_idx_next     = o_idx_reg;
        o_st_next      = o_st_reg;
        o_last_next    = o_last_reg;
        oidx_next      = oidx_reg;
        ost_next       = ost_reg;
        olast_next     = olast_reg;
        div_start      = 1'b0;
        head_we        = 1'b0;
        head_waddr     = clr_reg;
        head_wdata     = '0;
        head_re        = 1'b0;
        head_raddr     = cbkt_reg;
        pt_we          = 1'b0;
        pt_waddr       = count_reg[IDX_W-1:0];
        pt_wdata       = {x_reg, y_reg, head_rdata_reg};
        pt_re          = 1'b0;
        pt_raddr       = link_reg;

        case (state_reg)
            S_CLEAR:
            begin
                head_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BKT_W'(BUCKETS - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                rr_next = mul_p[59:0];
                if (accept)
                begin
                    req_next   = req_type;
                    x_next     = coord_x;
                    y_next     = coord_y;
                    axy_next   = 1'b0;
                    axi_next   = 2'd0;
                    nb_next    = '0;
                    nf_next    = '0;
                    state_next = S_DIVSTART;
                end
            end

            // cell coordinate for each in-box probe axis value
            S_DIVSTART:
            begin
                if (axy_reg ? iny[axi_reg] : inx[axi_reg])
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVWAIT;
                end
                else if (axy_reg && (axi_reg == 2'd2))
                begin
                    pi_next    = 2'd0;
                    pj_next    = 2'd0;
                    state_next = S_MUL;
                end
                else if (axi_reg == 2'd2)
                begin
                    axy_next = 1'b1;
                    axi_next = 2'd0;
                end
                else
                    axi_next = axi_reg + 1'b1;
            end

            S_DIVWAIT:
            begin
                if (div_done)
                begin
                    if (axy_reg)
                        cqy_next[axi_reg] = div_quo[31:0];
                    else
                        cqx_next[axi_reg] = div_quo[31:0];
                    if (axy_reg && (axi_reg == 2'd2))
                    begin
                        pi_next    = 2'd0;
                        pj_next    = 2'd0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        if (axi_reg == 2'd2)
                        begin
                            axy_next = 1'b1;
                            axi_next = 2'd0;
                        end
                        else
                            axi_next = axi_reg + 1'b1;
                        state_next = S_DIVSTART;
                    end
                end
            end

            // row product of the probe, then bucket from the low bits
            S_MUL:
            begin
                if (probe_in)
                begin
                    prod_next  = mul_p[47:0];
                    state_next = S_BKT;
                end
                else if (probe_last)
                begin
                    k_next     = '0;
                    state_next = after_probe;
                end
                else if (pj_reg == 2'd2)
                begin
                    pj_next = 2'd0;
                    pi_next = pi_reg + 1'b1;
                end
                else
                    pj_next = pj_reg + 1'b1;
            end

            S_BKT:
            begin
                if (!dup && (nb_reg < 3'd4))
                begin
                    list_next[nb_reg[1:0]] = bkt;
                    nb_next = nb_reg + 1'b1;
                end
                if ((pi_reg == 2'd1) && (pj_reg == 2'd1))
                    cbkt_next = bkt;
                if (probe_last)
                begin
                    k_next     = '0;
                    state_next = after_probe;
                end
                else
                begin
                    if (pj_reg == 2'd2)
                    begin
                        pj_next = 2'd0;
                        pi_next = pi_reg + 1'b1;
                    end
                    else
                        pj_next = pj_reg + 1'b1;
                    state_next = S_MUL;
                end
            end

            // chain walk over listed buckets
            S_HEAD:
            begin
                if (k_reg == nb_reg)
                begin
                    if (req_reg == ghpm_pkg::REQ_INSERT_UNIQUE)
                        state_next = S_INS;
                    else
                    begin
                        o_last_next = 1'b1;
                        ret_next    = S_IDLE;
                        state_next  = S_OUT;
                        if ((req_reg == ghpm_pkg::REQ_FIND_ALL) && (nf_reg != '0))
                        begin
                            o_idx_next = pend_reg;
                            o_st_next  = ghpm_pkg::ST_MATCHED;
                        end
                        else
                        begin
                            o_idx_next = '0;
                            o_st_next  = ghpm_pkg::ST_NONE;
                        end
                    end
                end
                else
                begin
                    head_re    = 1'b1;
                    head_raddr = list_reg[k_reg[1:0]];
                    state_next = S_HEADWAIT;
                end
            end

            S_HEADWAIT:
            begin
                if (head_rdata_reg[IDX_W])
                begin
                    pt_re      = 1'b1;
                    pt_raddr   = head_rdata_reg[IDX_W-1:0];
                    p_next     = head_rdata_reg[IDX_W-1:0];
                    state_next = S_PTWAIT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_HEAD;
                end
            end

            S_PTWAIT:
            begin
                near_next  = (adx < {3'b0, r_val}) && (ady < {3'b0, r_val});
                ax_next    = adx[29:0];
                ay_next    = ady[29:0];
                linkv_next = pt_rdata_reg[IDX_W];
                link_next  = pt_rdata_reg[IDX_W-1:0];
                state_next = S_SQX;
            end

            S_SQX:
            begin
                sqx_next   = mul_p[59:0];
                state_next = S_SQY;
            end

            S_SQY:
            begin
                sqy_next   = mul_p[59:0];
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (!close)
                    state_next = S_NEXT;
                else if (req_reg != ghpm_pkg::REQ_FIND_ALL)
                begin
                    o_idx_next  = p_reg;
                    o_st_next   = ghpm_pkg::ST_MATCHED;
                    o_last_next = 1'b1;
                    ret_next    = S_IDLE;
                    state_next  = S_OUT;
                end
                else if (nf_reg == '0)
                begin
                    pend_next  = p_reg;
                    nf_next    = NF_W'(1);
                    state_next = S_NEXT;
                end
                else
                begin
                    // previous match is not the last one
                    o_idx_next  = pend_reg;
                    o_st_next   = ghpm_pkg::ST_MATCHED;
                    o_last_next = 1'b0;
                    pend_next   = p_reg;
                    state_next  = S_OUT;
                    if (nf_reg == NF_W'(MAX_MATCHES))
                        ret_next = S_OVF;
                    else
                    begin
                        nf_next  = nf_reg + 1'b1;
                        ret_next = S_NEXT;
                    end
                end
            end

            S_NEXT:
            begin
                if (linkv_reg)
                begin
                    pt_re      = 1'b1;
                    pt_raddr   = link_reg;
                    p_next     = link_reg;
                    state_next = S_PTWAIT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_HEAD;
                end
            end

            S_OVF:
            begin
                o_idx_next  = '0;
                o_st_next   = ghpm_pkg::ST_OVERFLOW;
                o_last_next = 1'b1;
                ret_next    = S_IDLE;
                state_next  = S_OUT;
            end

            // insert at the head of the center bucket
            S_INS:
            begin
                o_idx_next  = '0;
                o_last_next = 1'b1;
                ret_next    = S_IDLE;
                if (!(inx[1] && iny[1]))
                begin
                    o_st_next  = ghpm_pkg::ST_OUTSIDE;
                    state_next = S_OUT;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    o_st_next  = ghpm_pkg::ST_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    head_re    = 1'b1;
                    head_raddr = cbkt_reg;
                    state_next = S_INSW;
                end
            end

            S_INSW:
            begin
                pt_we       = 1'b1;
                head_we     = 1'b1;
                head_waddr  = cbkt_reg;
                head_wdata  = {1'b1, count_reg[IDX_W-1:0]};
                count_next  = count_reg + 1'b1;
                o_idx_next  = count_reg[IDX_W-1:0];
                o_st_next   = ghpm_pkg::ST_INSERTED;
                o_last_next = 1'b1;
                ret_next    = S_IDLE;
                state_next  = S_OUT;
            end

            // hand the result to the output register
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    oidx_next      = o_idx_reg;
                    ost_next       = o_st_reg;
                    olast_next     = o_last_reg;
                    state_next     = ret_reg;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            clr_reg       <= '0;
            axy_reg       <= 1'b0;
            axi_reg       <= '0;
            pi_reg        <= '0;
            pj_reg        <= '0;
            nb_reg        <= '0;
            k_reg         <= '0;
            nf_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_reg       <= clr_next;
            axy_reg       <= axy_next;
            axi_reg       <= axi_next;
            pi_reg        <= pi_next;
            pj_reg        <= pj_next;
            nb_reg        <= nb_next;
            k_reg         <= k_next;
            nf_reg        <= nf_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rr_reg     <= rr_next;
        cqx_reg    <= cqx_next;
        cqy_reg    <= cqy_next;
        prod_reg   <= prod_next;
        list_reg   <= list_next;
        cbkt_reg   <= cbkt_next;
        p_reg      <= p_next;
        link_reg   <= link_next;
        linkv_reg  <= linkv_next;
        near_reg   <= near_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        pend_reg   <= pend_next;
        o_idx_reg  <= o_idx_next;
        o_st_reg   <= o_st_next;
        o_last_reg <= o_last_next;
        oidx_reg   <= oidx_next;
        ost_reg    <= ost_next;
        olast_reg  <= olast_next;
    end

    // bucket head memory: valid bit and head pointer
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        if (head_re)
            head_rdata_reg <= head_mem[head_raddr];
    end

    // point memory: x, y, link valid, link
    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= pt_wdata;
        if (pt_re)
            pt_rdata_reg <= pt_mem[pt_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign point_index = oidx_reg;
    assign status      = ost_reg;
    assign last_result = olast_reg;

endmodule

// ----- rtl/core/grid_hash_point_merge_core.sv -----
// ----------------------------------------------------------------------------
// grid_hash_point_merge_core
// Uniform-grid spatial hash of 2D Q16.16 points with radius matching.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------
//  in       | in_valid/in_stall  | req_type, coord_x, coord_y
//  out      | out_valid/out_stall| point_index, status, last_result
//  cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One request at a time. Cell numbers take up to six divisions, one per
//  in-box probe axis value; an out-of-box value skips its division. Every
//  in-box probe adds a row multiply and a bucket from the low bits (BUCKETS is
//  a power of two); each chained point is read, squared and compared, and each
//  listed bucket has its head read. After reset the head memory is cleared
//  before the first request is taken. Results leave through an output register,
//  so a new request is taken while the last result waits for out_stall to drop.
// ----------------------------------------------------------------------------
module grid_hash_point_merge_core #(
    parameter int CAPACITY    = ghpm_pkg::CAPACITY_DEF,
    parameter int BUCKETS     = ghpm_pkg::BUCKETS_DEF,
    parameter int MAX_MATCHES = ghpm_pkg::MAX_MATCHES_DEF,
    localparam int IDX_W      = $clog2(CAPACITY)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       req_type,
    input  logic [31:0]      coord_x,
    input  logic [31:0]      coord_y,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [IDX_W-1:0] point_index,
    output logic [2:0]       status,
    output logic             last_result
);

    ghpm_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ghpm_pkg::CFG_BOX_MIN_X:    cfg_next.box_min_x    = cfg_data;
                ghpm_pkg::CFG_BOX_MIN_Y:    cfg_next.box_min_y    = cfg_data;
                ghpm_pkg::CFG_BOX_MAX_X:    cfg_next.box_max_x    = cfg_data;
                ghpm_pkg::CFG_BOX_MAX_Y:    cfg_next.box_max_y    = cfg_data;
                ghpm_pkg::CFG_MATCH_RADIUS: cfg_next.match_radius = cfg_data[29:0];
                ghpm_pkg::CFG_ROW_STRIDE:   cfg_next.row_stride   = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_min_x    <= '0;
            cfg_reg.box_min_y    <= '0;
            cfg_reg.box_max_x    <= ghpm_pkg::BOX_MAX_RST;
            cfg_reg.box_max_y    <= ghpm_pkg::BOX_MAX_RST;
            cfg_reg.match_radius <= ghpm_pkg::RADIUS_RST;
            cfg_reg.row_stride   <= ghpm_pkg::STRIDE_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    ghpm_seq #(
        .CAPACITY    (CAPACITY),
        .BUCKETS     (BUCKETS),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_index (point_index),
        .status      (status),
        .last_result (last_result)
    );

endmodule
